// ----- rtl/pec_checked_response_receiver_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checked response receiver
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef PEC_CHECKED_RESPONSE_RECEIVER_CORE_DEFINES_SVH
`define PEC_CHECKED_RESPONSE_RECEIVER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCRR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcrr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pcrr assertion failed");

`endif

// ----- rtl/pcrr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrr_pkg
// Types, constants and the CRC-8 byte function of the response receiver.
// ----------------------------------------------------------------------------
package pcrr_pkg;

    localparam int C_MAX_CHIPS   = 8;
    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_DIV_STEPS   = 30;

    localparam logic [7:0]  C_CRC_POLY    = 8'h07;
    localparam logic [5:0]  C_BLOCK_MAX   = 6'd32;
    localparam logic [13:0] C_RATE_SCALE  = 14'd10000;
    localparam logic [15:0] C_TOTAL_LIMIT = 16'd64000;

    typedef enum logic [0:0] {
        CFG_BLOCK_BYTES = 1'b0,
        CFG_STACK_CHIPS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] chip;
        logic       ok;
        logic       last;
        logic [5:0] len;
    } t_blk;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_back_state;

    function automatic logic [7:0] crc8_byte(input logic [7:0] x);
        logic [7:0] c;
        c = x;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ C_CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/pcrr_front.sv -----
// ----------------------------------------------------------------------------
// pcrr_front
// Takes received bytes, runs the CRC over data bytes and queues one record
// per check byte.
// ----------------------------------------------------------------------------
module pcrr_front import pcrr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  logic       i_q_full,
    output logic       o_push,
    output t_blk       o_blk
);

    localparam logic [3:0] C_CHIP_LIM = (C_MAX_CHIPS > 8) ? 4'd8 : 4'(C_MAX_CHIPS);

    logic [5:0] r_block_bytes;
    logic [3:0] r_stack_chips;
    logic [7:0] r_crc, n_crc;
    logic [5:0] r_pos, n_pos;
    logic [2:0] r_chip, n_chip;

    logic [5:0] bb_eff;
    logic [3:0] chips_eff;
    logic [7:0] crc_cur;
    logic [5:0] pos_cur;
    logic [2:0] chip_cur;
    logic       last;
    logic       take;

    always_comb begin
        if (r_block_bytes == 6'd0) begin
            bb_eff = 6'd1;
        end else if (r_block_bytes > C_BLOCK_MAX) begin
            bb_eff = C_BLOCK_MAX;
        end else begin
            bb_eff = r_block_bytes;
        end
        if (r_stack_chips == 4'd0) begin
            chips_eff = 4'd1;
        end else if (r_stack_chips > C_CHIP_LIM) begin
            chips_eff = C_CHIP_LIM;
        end else begin
            chips_eff = r_stack_chips;
        end
    end

    assign o_ready  = !i_q_full;
    assign take     = i_valid && o_ready;
    assign crc_cur  = i_frame_start ? 8'd0 : r_crc;
    assign pos_cur  = i_frame_start ? 6'd0 : r_pos;
    assign chip_cur = i_frame_start ? 3'd0 : r_chip;
    assign last     = ({1'b0, chip_cur} + 4'd1) >= chips_eff;

    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos;
        n_chip     = r_chip;
        o_push     = 1'b0;
        o_blk.chip = chip_cur;
        o_blk.ok   = (crc_cur == i_rx_byte);
        o_blk.last = last;
        o_blk.len  = bb_eff;
        if (take) begin
            if (pos_cur < bb_eff) begin
                n_crc  = crc8_byte(crc_cur ^ i_rx_byte);
                n_pos  = pos_cur + 6'd1;
                n_chip = chip_cur;
            end else begin
                o_push = 1'b1;
                n_crc  = 8'd0;
                n_pos  = 6'd0;
                n_chip = last ? 3'd0 : chip_cur + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= 6'd18;
            r_stack_chips <= 4'd8;
            r_crc         <= 8'd0;
            r_pos         <= 6'd0;
            r_chip        <= 3'd0;
        end else begin
            r_crc  <= n_crc;
            r_pos  <= n_pos;
            r_chip <= n_chip;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BLOCK_BYTES) begin
                    r_block_bytes <= i_cfg_data;
                end else begin
                    r_stack_chips <= i_cfg_data[3:0];
                end
            end
        end
    end

endmodule

// ----- rtl/pcrr_queue.sv -----
// ----------------------------------------------------------------------------
// pcrr_queue
// Short first-in first-out queue of block records between front and back.
// ----------------------------------------------------------------------------
module pcrr_queue import pcrr_pkg::*; #(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_blk i_blk,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_blk o_blk
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_blk          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_blk   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/pcrr_back.sv -----
// ----------------------------------------------------------------------------
// pcrr_back
// Updates the byte counters per block, divides for the error rate at frame
// end and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`include "pec_checked_response_receiver_core_defines.svh"

module pcrr_back import pcrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_blk        i_blk,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_chip_index,
    output logic        o_check_ok,
    output logic        o_frame_done,
    output logic [13:0] o_error_rate,
    output logic [15:0] o_byte_total,
    output logic [15:0] o_byte_bad
);

    localparam int DW = 30;
    localparam int NW = $clog2(C_DIV_STEPS);

    t_back_state r_state, n_state;

    logic [15:0]   r_total, n_total;
    logic [15:0]   r_bad, n_bad;
    logic [13:0]   r_rate, n_rate;
    logic [2:0]    r_chip, n_chip;
    logic          r_ok, n_ok;
    logic          r_last, n_last;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [16:0]   r_rem, n_rem;
    logic [NW-1:0] r_cnt, n_cnt;

    logic          r_o_valid, n_o_valid;
    logic [2:0]    r_o_chip;
    logic          r_o_ok;
    logic          r_o_last;
    logic [13:0]   r_o_rate;
    logic [15:0]   r_o_total;
    logic [15:0]   r_o_bad;
    logic          load_out;

    logic [16:0] sum_total;
    logic [16:0] sum_bad;
    logic [16:0] rem_shift;
    logic        rem_ge;

    assign sum_total = {1'b0, r_total} + {11'd0, i_blk.len};
    assign sum_bad   = {1'b0, r_bad} + {11'd0, i_blk.len};
    assign rem_shift = {r_rem[15:0], r_dvd[DW-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_bad     = r_bad;
        n_rate    = r_rate;
        n_chip    = r_chip;
        n_ok      = r_ok;
        n_last    = r_last;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        o_pop     = 1'b0;
        load_out  = 1'b0;
        n_o_valid = r_o_valid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_chip  = i_blk.chip;
                    n_ok    = i_blk.ok;
                    n_last  = i_blk.last;
                    n_total = sum_total[16] ? 16'hFFFF : sum_total[15:0];
                    if (!i_blk.ok) begin
                        n_bad = sum_bad[16] ? 16'hFFFF : sum_bad[15:0];
                    end
                    n_state = i_blk.last ? S_MUL : S_EMIT;
                end
            end
            S_MUL: begin
                n_dvd   = {14'd0, r_bad} * {16'd0, C_RATE_SCALE};
                n_rem   = 17'd0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = rem_ge ? rem_shift - {1'b0, r_total} : rem_shift;
                n_dvd = {r_dvd[DW-2:0], rem_ge};
                n_cnt = r_cnt + NW'(1);
                if (r_cnt == NW'(C_DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_total == 16'd0) begin
                    n_rate = 14'd0;
                end else if (r_dvd > DW'(C_RATE_SCALE)) begin
                    n_rate = C_RATE_SCALE;
                end else begin
                    n_rate = r_dvd[13:0];
                end
                if (r_total > C_TOTAL_LIMIT) begin
                    n_total = 16'd1;
                    n_bad   = 16'd0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= 16'd0;
            r_bad     <= 16'd0;
            r_rate    <= 14'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_bad     <= n_bad;
            r_rate    <= n_rate;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chip <= n_chip;
        r_ok   <= n_ok;
        r_last <= n_last;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        if (load_out) begin
            r_o_chip  <= r_chip;
            r_o_ok    <= r_ok;
            r_o_last  <= r_last;
            r_o_rate  <= r_rate;
            r_o_total <= r_total;
            r_o_bad   <= r_bad;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_chip_index = r_o_chip;
    assign o_check_ok   = r_o_ok;
    assign o_frame_done = r_o_last;
    assign o_error_rate = r_o_rate;
    assign o_byte_total = r_o_total;
    assign o_byte_bad   = r_o_bad;

    `PCRR_ASSERT_SAME(a_bad_le_total, i_clk, i_rst_n, 1'b1, r_bad <= r_total)
    `PCRR_ASSERT_SAME(a_rate_in_range, i_clk, i_rst_n, 1'b1, r_rate <= C_RATE_SCALE)
    `PCRR_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n,
        r_state == S_DIV && r_cnt == NW'(C_DIV_STEPS - 1), r_state == S_FIN)

endmodule

// ----- rtl/pec_checked_response_receiver_core.sv -----
// Path: a check byte's record passes through the record queue, the back end's S_IDLE
// and S_EMIT states and the output register; a frame-ending block also passes S_MUL,
// S_DIV and S_FIN. Throughput: one byte per cycle at the input while the 2-entry record
// queue has room; the bit-serial rate divider sets the cost of each frame end.
// Reset: synchronous, active low; clears CRC, positions, counters, rate and queue,
// and loads 18 data bytes per chip and 8 chips.
// ----------------------------------------------------------------------------
// pec_checked_response_receiver_core
// Top level: checks CRC-8 protected chip blocks and keeps error statistics.
// ----------------------------------------------------------------------------
module pec_checked_response_receiver_core import pcrr_pkg::*; #(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_chip_index,
    output logic        o_check_ok,
    output logic        o_frame_done,
    output logic [13:0] o_error_rate,
    output logic [15:0] o_byte_total,
    output logic [15:0] o_byte_bad
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_blk blk_in;
    t_blk blk_out;

    pcrr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_blk         (blk_in)
    );

    pcrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_blk   (blk_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_blk   (blk_out)
    );

    pcrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_blk        (blk_out),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chip_index (o_chip_index),
        .o_check_ok   (o_check_ok),
        .o_frame_done (o_frame_done),
        .o_error_rate (o_error_rate),
        .o_byte_total (o_byte_total),
        .o_byte_bad   (o_byte_bad)
    );

endmodule

// ----- dv/tb_pec_checked_response_receiver_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the checked response receiver
// Bytes of daisy-chained read responses are sent through the valid/ready
// input, and every result beat is compared field by field with a cycle-free
// model of the CRC-8 block check, the byte counters and the error rate.
// Directed cases come first. A receiver hold-off follows, then random framed
// traffic over many register settings, and lastly a stretch of frames sent
// back to back with no idling on either side.
// ----------------------------------------------------------------------------
module tb_pec_checked_response_receiver_core import pcrr_pkg::*; ;

    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [2:0]  chip_index;
        logic        check_ok;
        logic        frame_done;
        logic [13:0] error_rate;
        logic [15:0] byte_total;
        logic [15:0] byte_bad;
    } t_block_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [5:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        i_frame_start;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_chip_index;
    logic        o_check_ok;
    logic        o_frame_done;
    logic [13:0] o_error_rate;
    logic [15:0] o_byte_total;
    logic [15:0] o_byte_bad;

    t_block_report pending_reports[$];

    logic [5:0]  blk_len_reg   = 6'd18;
    logic [3:0]  chip_cnt_reg  = 4'd8;
    logic [7:0]  crc_run       = 8'd0;
    logic [5:0]  byte_pos      = 6'd0;
    logic [2:0]  chip_pos      = 3'd0;
    int unsigned data_total    = 0;
    int unsigned data_bad      = 0;
    logic [13:0] rate_held     = 14'd0;

    int fail_count  = 0;
    int beats_sent  = 0;
    int hold_cycles = 0;
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;

    pec_checked_response_receiver_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_chip_index  (o_chip_index),
        .o_check_ok    (o_check_ok),
        .o_frame_done  (o_frame_done),
        .o_error_rate  (o_error_rate),
        .o_byte_total  (o_byte_total),
        .o_byte_bad    (o_byte_bad)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? C_CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic int block_len_eff();
        if (blk_len_reg == 6'd0) begin
            return 1;
        end
        if (blk_len_reg > C_BLOCK_MAX) begin
            return int'(C_BLOCK_MAX);
        end
        return int'(blk_len_reg);
    endfunction

    function automatic int chip_count_eff();
        int lim;
        lim = (C_MAX_CHIPS > 8) ? 8 : C_MAX_CHIPS;
        if (chip_cnt_reg == 4'd0) begin
            return 1;
        end
        if (int'(chip_cnt_reg) > lim) begin
            return lim;
        end
        return int'(chip_cnt_reg);
    endfunction

    function automatic int unsigned add_sat16(input int unsigned a, input int unsigned b);
        return (a + b > 32'hFFFF) ? 32'hFFFF : a + b;
    endfunction

    // Advances the block check state by one accepted byte and queues the
    // report that a check byte produces.
    function automatic void predict_block_report(input logic [7:0] data, input logic start);
        t_block_report   rep;
        int              blen;
        longint unsigned ratio;
        blen = block_len_eff();
        if (start) begin
            byte_pos = 6'd0;
            chip_pos = 3'd0;
            crc_run  = 8'd0;
        end
        if (int'(byte_pos) < blen) begin
            crc_run  = crc8_step(crc_run, data);
            byte_pos = byte_pos + 6'd1;
            return;
        end
        rep.check_ok = (crc_run == data);
        data_total   = add_sat16(data_total, blen);
        if (!rep.check_ok) begin
            data_bad = add_sat16(data_bad, blen);
        end
        rep.chip_index = chip_pos;
        rep.frame_done = (int'(chip_pos) + 1 >= chip_count_eff());
        if (rep.frame_done) begin
            ratio = 0;
            if (data_total != 0) begin
                ratio = (longint'(data_bad) * C_RATE_SCALE) / data_total;
            end
            if (ratio > C_RATE_SCALE) begin
                ratio = C_RATE_SCALE;
            end
            rate_held = ratio[13:0];
            if (data_total > C_TOTAL_LIMIT) begin
                data_total = 1;
                data_bad   = 0;
            end
            chip_pos = 3'd0;
        end else begin
            chip_pos = chip_pos + 3'd1;
        end
        byte_pos        = 6'd0;
        crc_run         = 8'd0;
        rep.error_rate  = rate_held;
        rep.byte_total  = data_total[15:0];
        rep.byte_bad    = data_bad[15:0];
        pending_reports.push_back(rep);
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_block_report exp_rep;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                $error("result beat with no expected report");
            end else begin
                exp_rep = pending_reports.pop_front();
                check_field("chip_index", exp_rep.chip_index, o_chip_index);
                check_field("check_ok",   exp_rep.check_ok,   o_check_ok);
                check_field("frame_done", exp_rep.frame_done, o_frame_done);
                check_field("error_rate", exp_rep.error_rate, o_error_rate);
                check_field("byte_total", exp_rep.byte_total, o_byte_total);
                check_field("byte_bad",   exp_rep.byte_bad,   o_byte_bad);
            end
        end
    end

    initial begin
        i_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
                i_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic start);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= data;
        i_frame_start <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_block_report(data, start);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_block(input bit start, input bit good);
        logic [7:0] crc;
        logic [7:0] data;
        int         blen;
        blen = block_len_eff();
        crc  = 8'd0;
        for (int i = 0; i < blen; i++) begin
            data = 8'($urandom);
            crc  = crc8_step(crc, data);
            send_beat(data, start && i == 0);
        end
        send_beat(good ? crc : crc ^ 8'($urandom_range(1, 255)), 1'b0);
    endtask

    task automatic send_frame(input bit start, input int good_pct);
        int chips;
        chips = chip_count_eff();
        for (int c = 0; c < chips; c++) begin
            send_block(start && c == 0, $urandom_range(1, 100) <= good_pct);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [5:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_BLOCK_BYTES) begin
            blk_len_reg = val;
        end else begin
            chip_cnt_reg = val[3:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_reset_values();
        logic [7:0] crc;
        logic [7:0] data;
        crc = 8'd0;
        for (int i = 0; i < 18; i++) begin
            data = i[0] ? 8'hFF : 8'h00;
            crc  = crc8_step(crc, data);
            send_beat(data, i == 0);
        end
        send_beat(crc, 1'b0);
        settle();
    endtask

    task automatic test_length_clamps();
        write_reg(CFG_BLOCK_BYTES, 6'd0);
        write_reg(CFG_STACK_CHIPS, 6'd0);
        send_block(1'b1, 1'b1);
        send_block(1'b0, 1'b0);
        send_block(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_frame_restart();
        write_reg(CFG_BLOCK_BYTES, 6'd3);
        write_reg(CFG_STACK_CHIPS, 6'd2);
        send_beat(8'h5A, 1'b1);
        send_beat(8'hA5, 1'b0);
        send_frame(1'b1, 100);
        settle();
    endtask

    task automatic test_config_mid_block();
        logic [7:0] crc;
        logic [7:0] data;
        write_reg(CFG_BLOCK_BYTES, 6'd6);
        write_reg(CFG_STACK_CHIPS, 6'd1);
        crc = 8'd0;
        for (int i = 0; i < 4; i++) begin
            data = 8'($urandom);
            crc  = crc8_step(crc, data);
            send_beat(data, i == 0);
        end
        settle();
        write_reg(CFG_BLOCK_BYTES, 6'd2);
        send_beat(crc, 1'b0);
        settle();
    endtask

    task automatic test_receiver_holdoff();
        tx_idle_en = 1'b0;
        write_reg(CFG_BLOCK_BYTES, 6'd1);
        write_reg(CFG_STACK_CHIPS, 6'd3);
        hold_cycles = 250;
        repeat (7) send_frame(1'b1, 80);
        settle();
    endtask

    task automatic test_random_frames();
        int start_count;
        int phase;
        int target;
        int pick;
        int k;
        bit need_start;
        start_count = beats_sent;
        phase       = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        while (beats_sent - start_count < 360) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_BLOCK_BYTES, 6'd1);
                    write_reg(CFG_STACK_CHIPS, 6'd8);
                end
                1: begin
                    write_reg(CFG_BLOCK_BYTES, 6'd32);
                    write_reg(CFG_STACK_CHIPS, 6'd1);
                end
                2: begin
                    write_reg(CFG_BLOCK_BYTES, 6'd0);
                    write_reg(CFG_STACK_CHIPS, 6'h3F);
                end
                3: begin
                    write_reg(CFG_BLOCK_BYTES, 6'h3F);
                    write_reg(CFG_STACK_CHIPS, 6'd0);
                end
                default: begin
                    write_reg(CFG_BLOCK_BYTES, ($urandom_range(0, 9) < 7) ?
                              6'($urandom_range(1, 6)) : 6'($urandom_range(0, 63)));
                    write_reg(CFG_STACK_CHIPS, 6'($urandom_range(0, 63)));
                end
            endcase
            phase++;
            need_start = 1'b1;
            target     = beats_sent + 60;
            while (beats_sent < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    send_frame(need_start || $urandom_range(0, 2) == 0, 75);
                    need_start = 1'b0;
                end else if (pick == 8) begin
                    k = $urandom_range(1, (block_len_eff() + 1) * chip_count_eff() - 1);
                    for (int i = 0; i < k; i++) begin
                        send_beat(8'($urandom), i == 0);
                    end
                    need_start = 1'b1;
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        send_beat(8'($urandom), $urandom_range(0, 7) == 0);
                    end
                    need_start = 1'b1;
                end
            end
        end
        settle();
    endtask

    task automatic test_back_to_back_tail();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(CFG_BLOCK_BYTES, 6'd4);
        write_reg(CFG_STACK_CHIPS, 6'd3);
        repeat (3) send_frame(1'b1, 70);
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_BLOCK_BYTES;
        i_cfg_data    = 6'd0;
        i_valid       = 1'b0;
        i_rx_byte     = 8'd0;
        i_frame_start = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_length_clamps();
        test_frame_restart();
        test_config_mid_block();
        test_receiver_holdoff();
        test_random_frames();
        test_back_to_back_tail();

        if (fail_count == 0) begin
            $display("pec_checked_response_receiver_core verification clean");
        end else begin
            $display("pec_checked_response_receiver_core verification failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("pec_checked_response_receiver_core verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcrr_pkg.sv
rtl/pcrr_front.sv
rtl/pcrr_queue.sv
rtl/pcrr_back.sv
rtl/pec_checked_response_receiver_core.sv
dv/tb_pec_checked_response_receiver_core.sv
